// ----- rtl/fffm_pkg.sv -----
// Package for the frequency filter mask generator.
// Widths, fixed-point constants, register indexes and sideband types.
// No dependencies.
package fffm_pkg;

  localparam int CoordW = 10;
  localparam int OrderW = 4;
  localparam int GainW  = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 10;
  localparam int SqW    = 2 * CoordW;
  localparam int D2W    = SqW + 1;
  localparam int FracW  = 16;
  localparam int RatioDvdW = D2W + FracW;
  localparam int PowW   = 34;
  localparam int MaxDim = 1024;

  localparam logic [PowW-1:0]  OneQ16 = PowW'(64'd65536);
  localparam logic [PowW-1:0]  PSat   = PowW'(64'd1 << 33);
  localparam logic [GainW-1:0] GainOne = GainW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 3'd0,
    CFG_CROW   = 3'd1,
    CFG_CCOL   = 3'd2,
    CFG_ORDER  = 3'd3,
    CFG_CUTOFF = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic oob;
    logic ideal_pass;
    logic d2_zero;
  } side_t;

  localparam int SideW = $bits(side_t);

endpackage

// ----- rtl/fffm_if.sv -----
// Handshake channels of the frequency filter mask generator.
// Depends on fffm_pkg.
interface fffm_in_if;
  logic                          valid;
  logic                          ready;
  logic [fffm_pkg::CoordW-1:0]   row;
  logic [fffm_pkg::CoordW-1:0]   col;
  modport source (output valid, row, col, input ready);
  modport sink   (input valid, row, col, output ready);
endinterface

interface fffm_out_if;
  logic                          valid;
  logic                          ready;
  logic [fffm_pkg::GainW-1:0]    gain;
  modport source (output valid, gain, input ready);
  modport sink   (input valid, gain, output ready);
endinterface

interface fffm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fffm_pkg::CfgIdxW-1:0]  index;
  logic [fffm_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/fffm_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Advances when en_i is high. No package dependency.
module fffm_div #(
  parameter int DW = 37,
  parameter int VW = 20,
  parameter int SW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [VW-1:0] dvs_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [DW];
  logic [VW-1:0] rem_q  [DW];
  logic [DW-1:0] dvd_q  [DW];
  logic [DW-1:0] quo_q  [DW];
  logic [VW-1:0] dvs_q  [DW];
  logic [SW-1:0] side_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_st
    logic          v_in;
    logic [VW-1:0] rem_in;
    logic [DW-1:0] dvd_in;
    logic [DW-1:0] quo_in;
    logic [VW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign dvd_in  = dvd_i;
      assign quo_in  = '0;
      assign dvs_in  = dvs_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, dvd_in[DW-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign take  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[VW-1:0] : trial[VW-1:0];
        dvd_q[k]  <= {dvd_in[DW-2:0], 1'b0};
        quo_q[k]  <= {quo_in[DW-2:0], take};
        dvs_q[k]  <= dvs_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[DW-1];
  assign quo_o   = quo_q[DW-1];
  assign side_o  = side_q[DW-1];

endmodule

// ----- rtl/fffm_pow.sv -----
// Power pipeline: at most one saturating Q.16 multiply per register stage;
// stages at or beyond order_i pass the product through. Depends on fffm_pkg.
module fffm_pow #(
  parameter int NS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [fffm_pkg::OrderW-1:0]   order_i,
  input  logic                          valid_i,
  input  logic [fffm_pkg::PowW-1:0]     q_i,
  input  fffm_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [fffm_pkg::PowW-1:0]     p_o,
  output fffm_pkg::side_t               side_o
);

  localparam int PW = fffm_pkg::PowW;

  logic            v_q    [NS];
  logic [PW-1:0]   p_q    [NS];
  logic [PW-1:0]   q_q    [NS];
  fffm_pkg::side_t side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic            v_in;
    logic [PW-1:0]   p_in;
    logic [PW-1:0]   q_in;
    fffm_pkg::side_t side_in;
    logic [2*PW-1:0] prod;
    logic [2*PW-1:0] rnd;
    logic [2*PW-1:0] shr;
    logic [PW-1:0]   p_new;
    logic            act;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign p_in    = fffm_pkg::OneQ16;
      assign q_in    = q_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign p_in    = p_q[k-1];
      assign q_in    = q_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign prod  = (2*PW)'(p_in) * (2*PW)'(q_in);
    assign rnd   = prod + (2*PW)'(32768);
    assign shr   = rnd >> fffm_pkg::FracW;
    assign p_new = (shr > (2*PW)'(fffm_pkg::PSat)) ? fffm_pkg::PSat : shr[PW-1:0];
    assign act   = (5'(order_i) > 5'(k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k]    <= act ? p_new : p_in;
        q_q[k]    <= q_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign p_o     = p_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ----- rtl/frequency_filter_mask_gen_unit.sv -----
// Low-pass frequency mask generator, Butterworth or ideal cutoff.
// Channels in_i (row, col), out_o (gain, unsigned Q1.16), cfg_i (register writes).
// One coordinate is accepted per cycle when out_o is not stalled.
// Pipeline: 3 front stages, 37 ratio-divider stages, MAX_ORDER power stages,
// 34 gain-divider stages and one output register.
// Throughput is one item per cycle; the whole pipeline advances together and
// freezes while a finished item sits in the output register unaccepted, so
// nothing is lost or repeated on a stall.
// Registers: 0 mode, 1 center row, 2 center col, 3 order, 4 cutoff radius.
// Writes to other indexes are dropped; cfg_i is always ready and must only
// be written while the pipeline is empty.
// Reset empties the pipeline and loads mode 1, center 512/512, order 1,
// cutoff 25. Orders above MAX_ORDER act as MAX_ORDER.
// Depends on fffm_pkg, fffm_if, fffm_div, fffm_pow.
module frequency_filter_mask_gen_unit #(
  parameter int MAX_ORDER = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fffm_in_if.sink    in_i,
  fffm_out_if.source out_o,
  fffm_cfg_if.sink   cfg_i
);

  localparam int CW = fffm_pkg::CoordW;
  localparam int OW = fffm_pkg::OrderW;
  localparam int PW = fffm_pkg::PowW;
  localparam int GW = fffm_pkg::GainW;
  localparam int RW = fffm_pkg::RatioDvdW;
  localparam int D2W = fffm_pkg::D2W;
  localparam int SqW = fffm_pkg::SqW;
  localparam int GdW = 34;

  logic          mode_q;
  logic [CW-1:0] crow_q, ccol_q, cutoff_q;
  logic [OW-1:0] order_q;
  logic [SqW-1:0] c2_q;
  logic [OW-1:0] order_eff;

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b1;
      crow_q   <= CW'(512);
      ccol_q   <= CW'(512);
      order_q  <= OW'(1);
      cutoff_q <= CW'(25);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        fffm_pkg::CFG_MODE:   mode_q   <= cfg_i.data[0];
        fffm_pkg::CFG_CROW:   crow_q   <= cfg_i.data[CW-1:0];
        fffm_pkg::CFG_CCOL:   ccol_q   <= cfg_i.data[CW-1:0];
        fffm_pkg::CFG_ORDER:  order_q  <= cfg_i.data[OW-1:0];
        fffm_pkg::CFG_CUTOFF: cutoff_q <= cfg_i.data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    c2_q <= SqW'(cutoff_q) * SqW'(cutoff_q);
  end

  assign order_eff = (5'(order_q) > 5'(MAX_ORDER)) ? OW'(MAX_ORDER) : order_q;

  // front stage 1: distances
  logic          s1_v_q, s1_oob_q;
  logic [CW-1:0] s1_dr_q, s1_dc_q;
  // front stage 2: squares
  logic           s2_v_q, s2_oob_q;
  logic [SqW-1:0] s2_sr_q, s2_sc_q;
  // front stage 3: squared distance
  logic           s3_v_q;
  logic [D2W-1:0] s3_d2_q;
  fffm_pkg::side_t s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  logic [D2W-1:0] d2_d;
  assign d2_d = D2W'(s2_sr_q) + D2W'(s2_sc_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dr_q  <= (in_i.row >= crow_q) ? in_i.row - crow_q : crow_q - in_i.row;
      s1_dc_q  <= (in_i.col >= ccol_q) ? in_i.col - ccol_q : ccol_q - in_i.col;
      s1_oob_q <= (13'(in_i.row) >= 13'(fffm_pkg::MaxDim)) ||
                  (13'(in_i.col) >= 13'(fffm_pkg::MaxDim));
      s2_sr_q  <= SqW'(s1_dr_q) * SqW'(s1_dr_q);
      s2_sc_q  <= SqW'(s1_dc_q) * SqW'(s1_dc_q);
      s2_oob_q <= s1_oob_q;
      s3_d2_q  <= d2_d;
      s3_side_q.oob        <= s2_oob_q;
      s3_side_q.ideal_pass <= (d2_d <= D2W'(c2_q));
      s3_side_q.d2_zero    <= (d2_d == '0);
    end
  end

  // ratio d2 / c2 in Q.16
  logic                       r_v;
  logic [RW-1:0]              r_quo;
  logic [fffm_pkg::SideW-1:0] r_side_raw;
  fffm_pkg::side_t            r_side;
  logic [PW-1:0]              q_val;

  fffm_div #(.DW(RW), .VW(SqW), .SW(fffm_pkg::SideW)) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .dvd_i   ({s3_d2_q, fffm_pkg::FracW'(0)}),
    .dvs_i   (c2_q),
    .side_i  (s3_side_q),
    .valid_o (r_v),
    .quo_o   (r_quo),
    .side_o  (r_side_raw)
  );

  assign r_side = r_side_raw;

  always_comb begin
    if (c2_q == '0) begin
      q_val = r_side.d2_zero ? '0 : fffm_pkg::PSat;
    end else if (r_quo > RW'(fffm_pkg::PSat)) begin
      q_val = fffm_pkg::PSat;
    end else begin
      q_val = r_quo[PW-1:0];
    end
  end

  // ratio raised to the order
  logic            p_v;
  logic [PW-1:0]   p_val;
  fffm_pkg::side_t p_side;

  fffm_pow #(.NS(MAX_ORDER)) u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .order_i (order_eff),
    .valid_i (r_v),
    .q_i     (q_val),
    .side_i  (r_side),
    .valid_o (p_v),
    .p_o     (p_val),
    .side_o  (p_side)
  );

  // gain = round(2^32 / (2^16 + p)), p in Q.16
  logic [GdW-1:0] den;
  logic [GdW-1:0] num;
  assign den = GdW'(fffm_pkg::OneQ16) + GdW'(p_val);
  assign num = (GdW'(1) << 32) + (den >> 1);

  logic                       g_v;
  logic [GdW-1:0]             g_quo;
  logic [fffm_pkg::SideW-1:0] g_side_raw;
  fffm_pkg::side_t            g_side;

  fffm_div #(.DW(GdW), .VW(GdW), .SW(fffm_pkg::SideW)) u_gain_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v),
    .dvd_i   (num),
    .dvs_i   (den),
    .side_i  (p_side),
    .valid_o (g_v),
    .quo_o   (g_quo),
    .side_o  (g_side_raw)
  );

  assign g_side = g_side_raw;

  logic          out_v_q;
  logic [GW-1:0] gain_q;
  logic [GW-1:0] gain_d;

  always_comb begin
    if (g_side.oob) begin
      gain_d = '0;
    end else if (!mode_q) begin
      gain_d = g_side.ideal_pass ? fffm_pkg::GainOne : '0;
    end else begin
      gain_d = g_quo[GW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= g_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gain_q <= gain_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.gain  = gain_q;

endmodule
